FILE: hw/rtl/spvg_pkg.sv
// Package for the sphere patch vertex generator: payload structs, config register
// indexes, CORDIC constants and shared helper functions. No dependencies.
`timescale 1ns / 1ps

package spvg_pkg;

    localparam int MAX_DIVISIONS_DEF = 1024;
    localparam int PHASE_BITS_DEF    = 16;

    localparam int CORDIC_ITERS  = 16;
    localparam int CORDIC_STAGES = CORDIC_ITERS / 2;
    // One stage for the octant reduction, the iteration stages, one rounding stage.
    localparam int CORDIC_LAT    = CORDIC_STAGES + 2;
    localparam int VERT_LAT      = 3;
    localparam int SIDE_LAT      = CORDIC_LAT + VERT_LAT;

    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    localparam logic [2:0] CFG_RADIUS   = 3'd0;
    localparam logic [2:0] CFG_Z_OFFSET = 3'd1;
    localparam logic [2:0] CFG_U_STEP   = 3'd2;
    localparam logic [2:0] CFG_V_STEP   = 3'd3;
    localparam logic [2:0] CFG_U_DIV    = 3'd4;

    typedef struct packed {
        logic [9:0] u_index;
        logic [9:0] v_index;
    } t_cell;

    typedef struct packed {
        logic [1:0]         corner;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [21:0]        vertex_number;
        logic               last_corner;
    } t_vertex;

    // Corner issued by the sequencer.
    typedef struct packed {
        logic        valid;
        logic [1:0]  corner;
        logic [10:0] u_pos;
        logic [10:0] v_pos;
        logic [9:0]  u_index;
        logic [9:0]  v_index;
    } t_seq_item;

    typedef struct packed {
        logic [1:0]  corner;
        logic [21:0] vertex_number;
    } t_side;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [23:0] z;
    } t_cstate;

    // Arc tangents of 2^-i in units of 2^-24 turn.
    function automatic logic signed [23:0] atan_turn24(input int i);
        logic signed [23:0] a;
        unique case (i)
            0:  a = 24'sd2097152;
            1:  a = 24'sd1238021;
            2:  a = 24'sd654133;
            3:  a = 24'sd332052;
            4:  a = 24'sd166669;
            5:  a = 24'sd83416;
            6:  a = 24'sd41718;
            7:  a = 24'sd20860;
            8:  a = 24'sd10430;
            9:  a = 24'sd5215;
            10: a = 24'sd2608;
            11: a = 24'sd1304;
            12: a = 24'sd652;
            13: a = 24'sd326;
            14: a = 24'sd163;
            15: a = 24'sd81;
            default: a = 24'sd0;
        endcase
        return a;
    endfunction

    function automatic t_cstate cordic_iter(input t_cstate s, input int i);
        t_cstate n;
        if (s.z >= 0) begin
            n.x = s.x - (s.y >>> i);
            n.y = s.y + (s.x >>> i);
            n.z = s.z - atan_turn24(i);
        end else begin
            n.x = s.x + (s.y >>> i);
            n.y = s.y - (s.x >>> i);
            n.z = s.z + atan_turn24(i);
        end
        return n;
    endfunction

endpackage

FILE: hw/rtl/spvg_seq.sv
// Cell sequencer: holds one accepted cell and issues its four corners, one per cycle while i_en is high.
// Depends on spvg_pkg.
`timescale 1ns / 1ps

module spvg_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_in_valid,
    input  spvg_pkg::t_cell     i_in_data,
    output logic                o_in_stall,
    output spvg_pkg::t_seq_item o_item
);
    import spvg_pkg::*;

    logic       r_busy;
    logic [1:0] r_k;
    logic [9:0] r_u;
    logic [9:0] r_v;
    logic       w_last;
    logic       w_take;

    assign w_last     = (r_k == 2'd3);
    assign o_in_stall = r_busy && !(i_en && w_last);
    assign w_take     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= 2'd0;
        end else if (w_take) begin
            r_busy <= 1'b1;
            r_k    <= 2'd0;
        end else if (i_en && r_busy) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end else begin
                r_k <= r_k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_u <= i_in_data.u_index;
            r_v <= i_in_data.v_index;
        end
    end

    // Corners 1 and 2 step u, corners 2 and 3 step v.
    always_comb begin
        o_item.valid   = r_busy;
        o_item.corner  = r_k;
        o_item.u_pos   = {1'b0, r_u} + {10'd0, r_k[0] ^ r_k[1]};
        o_item.v_pos   = {1'b0, r_v} + {10'd0, r_k[1]};
        o_item.u_index = r_u;
        o_item.v_index = r_v;
    end

endmodule

FILE: hw/rtl/spvg_cordic.sv
// Pipelined sine/cosine unit: octant reduction, two CORDIC iterations per stage,
// then rounding to Q1.14 and quadrant fix-up. Depends on spvg_pkg.
`timescale 1ns / 1ps

module spvg_cordic #(
    parameter int PHASE_BITS = spvg_pkg::PHASE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [PHASE_BITS-1:0] i_phase,
    output logic signed [15:0]    o_sin,
    output logic signed [15:0]    o_cos
);
    import spvg_pkg::*;

    t_cstate     r_st [CORDIC_STAGES+1];
    logic [1:0]  r_q  [CORDIC_STAGES+1];
    logic [23:0] w_p24;
    logic [24:0] w_t;

    assign w_p24 = 24'(i_phase) << (24 - PHASE_BITS);
    assign w_t   = {1'b0, w_p24} + 25'(2**21);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0]    <= w_t[23:22];
            r_st[0].x <= CORDIC_X0;
            r_st[0].y <= '0;
            r_st[0].z <= signed'({2'b00, w_t[21:0]}) - 24'sd2097152;
        end
    end

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
        t_cstate w_mid;
        t_cstate w_nxt;
        always_comb begin
            w_mid = cordic_iter(r_st[s], 2 * s);
            w_nxt = cordic_iter(w_mid, 2 * s + 1);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[s+1] <= w_nxt;
                r_q[s+1]  <= r_q[s];
            end
        end
    end

    logic signed [33:0] w_xr;
    logic signed [33:0] w_yr;
    logic signed [15:0] w_c;
    logic signed [15:0] w_s;
    logic signed [15:0] n_cos;
    logic signed [15:0] n_sin;

    always_comb begin
        w_xr = (r_st[CORDIC_STAGES].x + 34'sd32768) >>> 16;
        w_yr = (r_st[CORDIC_STAGES].y + 34'sd32768) >>> 16;
        if (w_xr > 34'sd16384) begin
            w_c = 16'sd16384;
        end else if (w_xr < -34'sd16384) begin
            w_c = -16'sd16384;
        end else begin
            w_c = 16'(w_xr);
        end
        if (w_yr > 34'sd16384) begin
            w_s = 16'sd16384;
        end else if (w_yr < -34'sd16384) begin
            w_s = -16'sd16384;
        end else begin
            w_s = 16'(w_yr);
        end
        unique case (r_q[CORDIC_STAGES])
            2'd0: begin
                n_cos = w_c;
                n_sin = w_s;
            end
            2'd1: begin
                n_cos = -w_s;
                n_sin = w_c;
            end
            2'd2: begin
                n_cos = -w_c;
                n_sin = -w_s;
            end
            default: begin
                n_cos = w_s;
                n_sin = -w_c;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= n_cos;
            o_sin <= n_sin;
        end
    end

endmodule

FILE: hw/rtl/spvg_vertex.sv
// Normal and position arithmetic: three stages of Q1.14 products, radius scaling,
// z offset and saturation. Depends on spvg_pkg.
`timescale 1ns / 1ps

module spvg_vertex (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_sin_u,
    input  logic signed [15:0] i_cos_u,
    input  logic signed [15:0] i_sin_v,
    input  logic signed [15:0] i_cos_v,
    input  logic [14:0]        i_radius,
    input  logic signed [15:0] i_z_offset,
    output logic signed [15:0] o_pos_x,
    output logic signed [15:0] o_pos_y,
    output logic signed [15:0] o_pos_z,
    output logic signed [15:0] o_norm_x,
    output logic signed [15:0] o_norm_y,
    output logic signed [15:0] o_norm_z
);
    import spvg_pkg::*;

    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        logic signed [15:0] r;
        if (v > 19'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -19'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

    logic signed [31:0] w_pnx;
    logic signed [31:0] w_pny;
    logic signed [15:0] r_nx_a;
    logic signed [15:0] r_ny_a;
    logic signed [15:0] r_nz_a;

    assign w_pnx = (32'(i_sin_v) * 32'(i_cos_u) + 32'sd8192) >>> 14;
    assign w_pny = (32'(i_sin_v) * 32'(i_sin_u) + 32'sd8192) >>> 14;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx_a <= 16'(w_pnx);
            r_ny_a <= 16'(w_pny);
            r_nz_a <= i_cos_v;
        end
    end

    logic signed [31:0] w_r;
    logic signed [31:0] w_px;
    logic signed [31:0] w_py;
    logic signed [31:0] w_pz;
    logic signed [17:0] r_px_b;
    logic signed [17:0] r_py_b;
    logic signed [17:0] r_pz_b;
    logic signed [15:0] r_nx_b;
    logic signed [15:0] r_ny_b;
    logic signed [15:0] r_nz_b;

    assign w_r  = signed'({17'd0, i_radius});
    assign w_px = (w_r * 32'(r_nx_a) + 32'sd8192) >>> 14;
    assign w_py = (w_r * 32'(r_ny_a) + 32'sd8192) >>> 14;
    assign w_pz = (w_r * 32'(r_nz_a) + 32'sd8192) >>> 14;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px_b <= 18'(w_px);
            r_py_b <= 18'(w_py);
            r_pz_b <= 18'(w_pz);
            r_nx_b <= r_nx_a;
            r_ny_b <= r_ny_a;
            r_nz_b <= r_nz_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_pos_x  <= sat16(19'(r_px_b));
            o_pos_y  <= sat16(19'(r_py_b));
            o_pos_z  <= sat16(19'(r_pz_b) + 19'(i_z_offset));
            o_norm_x <= r_nx_b;
            o_norm_y <= r_ny_b;
            o_norm_z <= r_nz_b;
        end
    end

endmodule

FILE: hw/rtl/sphere_patch_vertex_generator.sv
// Corners of an accepted cell follow one vertex per cycle while the output is not stalled;
// the corner sequencer takes the next cell as it issues the last corner, so cells run back to back.
// The whole pipeline holds while the output register is full and stalled.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults.
// Top level of the sphere patch vertex generator.
// Depends on spvg_pkg, spvg_seq, spvg_cordic and spvg_vertex.
`timescale 1ns / 1ps

module sphere_patch_vertex_generator #(
    parameter int MAX_DIVISIONS = spvg_pkg::MAX_DIVISIONS_DEF,
    parameter int PHASE_BITS    = spvg_pkg::PHASE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  spvg_pkg::t_cell   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output spvg_pkg::t_vertex o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);
    import spvg_pkg::*;

    logic [14:0]        r_radius;
    logic signed [15:0] r_z_offset;
    logic [15:0]        r_u_step;
    logic [15:0]        r_v_step;
    logic [10:0]        r_u_div;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= 15'd256;
            r_z_offset <= '0;
            r_u_step   <= 16'd4096;
            r_v_step   <= 16'd4096;
            r_u_div    <= 11'd16;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RADIUS:   r_radius   <= i_cfg_data[14:0];
                CFG_Z_OFFSET: r_z_offset <= signed'(i_cfg_data);
                CFG_U_STEP:   r_u_step   <= i_cfg_data;
                CFG_V_STEP:   r_v_step   <= i_cfg_data;
                CFG_U_DIV:    r_u_div    <= i_cfg_data[10:0];
                default:      ;
            endcase
        end
    end

    logic      w_en;
    t_seq_item w_item;

    assign w_en = !(o_out_valid && i_out_stall);

    spvg_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_item     (w_item)
    );

    // Phase products and vertex numbering.
    logic [10:0]           w_div;
    logic [26:0]           w_pu;
    logic [26:0]           w_pv;
    logic [23:0]           w_vnum;
    logic                  r_s1_valid;
    t_side                 r_s1_side;
    logic [PHASE_BITS-1:0] r_phase_u;
    logic [PHASE_BITS-1:0] r_phase_v;

    assign w_div  = (32'(r_u_div) > MAX_DIVISIONS) ? 11'(MAX_DIVISIONS) : r_u_div;
    assign w_pu   = 27'(w_item.u_pos) * 27'(r_u_step);
    assign w_pv   = 27'(w_item.v_pos) * 27'(r_v_step);
    assign w_vnum = {22'(22'(w_item.v_index) * 22'(w_div) + 22'(w_item.u_index)),
                     w_item.corner};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= w_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_phase_u               <= w_pu[PHASE_BITS-1:0];
            r_phase_v               <= w_pv[PHASE_BITS-1:0];
            r_s1_side.corner        <= w_item.corner;
            r_s1_side.vertex_number <= w_vnum[21:0];
        end
    end

    logic signed [15:0] w_sin_u;
    logic signed [15:0] w_cos_u;
    logic signed [15:0] w_sin_v;
    logic signed [15:0] w_cos_v;

    spvg_cordic #(.PHASE_BITS(PHASE_BITS)) u_cordic_u (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (r_phase_u),
        .o_sin   (w_sin_u),
        .o_cos   (w_cos_u)
    );

    spvg_cordic #(.PHASE_BITS(PHASE_BITS)) u_cordic_v (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (r_phase_v),
        .o_sin   (w_sin_v),
        .o_cos   (w_cos_v)
    );

    logic signed [15:0] w_pos_x;
    logic signed [15:0] w_pos_y;
    logic signed [15:0] w_pos_z;
    logic signed [15:0] w_norm_x;
    logic signed [15:0] w_norm_y;
    logic signed [15:0] w_norm_z;

    spvg_vertex u_vertex (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_sin_u    (w_sin_u),
        .i_cos_u    (w_cos_u),
        .i_sin_v    (w_sin_v),
        .i_cos_v    (w_cos_v),
        .i_radius   (r_radius),
        .i_z_offset (r_z_offset),
        .o_pos_x    (w_pos_x),
        .o_pos_y    (w_pos_y),
        .o_pos_z    (w_pos_z),
        .o_norm_x   (w_norm_x),
        .o_norm_y   (w_norm_y),
        .o_norm_z   (w_norm_z)
    );

    // Corner tags and valid bits ride alongside the arithmetic stages.
    logic  r_vld  [SIDE_LAT];
    t_side r_side [SIDE_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SIDE_LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= r_s1_valid;
            for (int i = 1; i < SIDE_LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= r_s1_side;
            for (int i = 1; i < SIDE_LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    assign o_out_valid = r_vld[SIDE_LAT-1];

    always_comb begin
        o_out_data.corner        = r_side[SIDE_LAT-1].corner;
        o_out_data.pos_x         = w_pos_x;
        o_out_data.pos_y         = w_pos_y;
        o_out_data.pos_z         = w_pos_z;
        o_out_data.norm_x        = w_norm_x;
        o_out_data.norm_y        = w_norm_y;
        o_out_data.norm_z        = w_norm_z;
        o_out_data.vertex_number = r_side[SIDE_LAT-1].vertex_number;
        o_out_data.last_corner   = (r_side[SIDE_LAT-1].corner == 2'd3);
    end

endmodule
